>>> src/char_stack_with_search_macros.svh
// ----------------------------------------------------------------------------
// char_stack_with_search_macros.svh
// Assertion macros used by the checker of the byte stack.
// ----------------------------------------------------------------------------
`ifndef CHAR_STACK_WITH_SEARCH_MACROS_SVH
`define CHAR_STACK_WITH_SEARCH_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define CSWS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define CSWS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/csws_pkg.sv
// ----------------------------------------------------------------------------
// csws_pkg
// Types and constants shared by the byte stack cells, control and checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package csws_pkg;

   localparam int DEPTH      = 64;
   localparam int CHAR_W     = 8;
   localparam int POS_W      = 7;
   localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   typedef enum logic [1:0] {
      CMD_PUSH   = 2'd0,
      CMD_SEARCH = 2'd1,
      CMD_READ   = 2'd2,
      CMD_POP    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_MISS  = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_DOWN,
      OP_UP
   } cell_op_type;

   typedef enum logic {
      STATE_IDLE,
      STATE_SCAN
   } state_type;

   typedef struct packed {
      status_type              status;
      logic [CHAR_W-1:0]       char_out;
      logic [POS_W-1:0]        position_out;
   } rsp_type;

endpackage

>>> src/char_stack_with_search.sv
// ----------------------------------------------------------------------------
// char_stack_with_search
// Bounded byte stack with search by content and read by position.
// ----------------------------------------------------------------------------
// The stack is a ring of DEPTH byte cells with the top of the stack always in
// cell 0. Push and pop shift the whole ring by one cell; they and every
// refused or failed command (full push, empty pop, search on an empty stack,
// read at position zero or below the bottom) are settled at acceptance, and
// the result word is registered and shows the next cycle. A search on a
// non-empty stack and a valid read rotate the ring upwards one cell per cycle
// until it has turned once round, so every entry passes cell 0 where it is
// compared or captured, and the ring is back in order at the end, when the
// result word is registered. One command is worked at a time; the next is
// taken once the result register is empty or being emptied in the same
// cycle. The cells have no reset and need no clearing pass: only entries
// below the depth count are ever looked at.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module char_stack_with_search
   import csws_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // command word
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [7:0] char_in, [14:8] position_in, [15] zero
   input  logic [1:0]            req_tuser,  // [1:0] command
   // result word
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [7:0] char_out, [14:8] position_out, [15] zero
   output logic [1:0]            rsp_tuser   // [1:0] status
);

   logic [CHAR_W-1:0] cell_data [DEPTH];
   cell_op_type       cell_op;
   rsp_type           rsp;

   // cell 0 is the top; pushing feeds it from the command word, and the
   // bottom cell closes the ring back to the top for rotation
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [CHAR_W-1:0] above;
      logic [CHAR_W-1:0] below;
      if (i == 0) begin : g_top
         assign above = req_tdata[CHAR_W-1:0];
      end else begin : g_mid
         assign above = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_bottom
         assign below = cell_data[0];
      end else begin : g_upper
         assign below = cell_data[i+1];
      end
      csws_cell u_cell (
         .clock      (clock),
         .cell_op    (cell_op),
         .from_above (above),
         .from_below (below),
         .data_out   (cell_data[i])
      );
   end

   csws_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (cmd_type'(req_tuser)),
      .req_char   (req_tdata[CHAR_W-1:0]),
      .req_pos    (req_tdata[CHAR_W+POS_W-1:CHAR_W]),
      .top_data   (cell_data[0]),
      .cell_op    (cell_op),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = {1'b0, rsp.position_out, rsp.char_out};
   assign rsp_tuser = rsp.status;

endmodule

>>> src/csws_cell.sv
// ----------------------------------------------------------------------------
// csws_cell
// One byte slot of the stack ring: holds, takes from above or from below.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csws_cell
   import csws_pkg::*;
(
   input  logic              clock,
   input  cell_op_type       cell_op,
   input  logic [CHAR_W-1:0] from_above,
   input  logic [CHAR_W-1:0] from_below,
   output logic [CHAR_W-1:0] data_out
);

   logic [CHAR_W-1:0] data_ff;
   logic [CHAR_W-1:0] data_in;

   always_comb begin
      unique case (cell_op)
         OP_DOWN: data_in = from_above;
         OP_UP:   data_in = from_below;
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

>>> src/csws_ctrl.sv
// ----------------------------------------------------------------------------
// csws_ctrl
// Command sequencer: depth count, ring scan for search and read, result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csws_ctrl
   import csws_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  cmd_type           req_cmd,
   input  logic [CHAR_W-1:0] req_char,
   input  logic [POS_W-1:0]  req_pos,
   input  logic [CHAR_W-1:0] top_data,
   output cell_op_type       cell_op,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output rsp_type           rsp
);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  step_ff, step_in;
   cmd_type           cmd_ff, cmd_in;
   logic [CHAR_W-1:0] key_ff, key_in;
   logic [POS_W-1:0]  rpos_ff, rpos_in;
   logic              hit_ff, hit_in;
   logic [POS_W-1:0]  hit_pos_ff, hit_pos_in;
   logic [CHAR_W-1:0] rd_char_ff, rd_char_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              accept;
   logic              needs_scan;
   rsp_type           imm_rsp;
   logic [CMP_W-1:0]  cnt_ext;
   logic [CMP_W-1:0]  req_pos_ext;
   logic [CMP_W-1:0]  step_pos;
   logic              scan_hit;
   logic              scan_rd;
   logic              is_empty;
   logic              is_full;

   assign is_empty    = (count_ff == '0);
   assign is_full     = (count_ff == FULL_CNT);
   assign cnt_ext     = CMP_W'(count_ff);
   assign req_pos_ext = CMP_W'(req_pos);
   // 1-based position from the top of the entry now sitting in cell 0
   assign step_pos    = CMP_W'(step_ff) + CMP_W'(1);
   assign scan_hit    = (top_data == key_ff) && (step_pos <= cnt_ext);
   assign scan_rd     = (step_pos == CMP_W'(rpos_ff));
   assign accept      = req_tvalid && req_tready;

   // result for commands settled at acceptance
   always_comb begin
      imm_rsp    = '{status: ST_OK, char_out: '0, position_out: '0};
      needs_scan = 1'b0;
      unique case (req_cmd)
         CMD_PUSH: begin
            if (is_full) imm_rsp.status = ST_FULL;
         end
         CMD_SEARCH: begin
            if (is_empty) imm_rsp.status = ST_MISS;
            else          needs_scan     = 1'b1;
         end
         CMD_READ: begin
            if (req_pos == POS_W'(1) && is_empty)               imm_rsp.status = ST_EMPTY;
            else if (req_pos == '0 || req_pos_ext > cnt_ext)    imm_rsp.status = ST_MISS;
            else                                                needs_scan     = 1'b1;
         end
         CMD_POP: begin
            if (is_empty) imm_rsp.status   = ST_EMPTY;
            else          imm_rsp.char_out = top_data;
         end
         default: ;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         STATE_IDLE: if (accept && needs_scan) state_in = STATE_SCAN;
         STATE_SCAN: if (step_ff == LAST_STEP) state_in = STATE_IDLE;
         default:    state_in = STATE_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_tready   = (state_ff == STATE_IDLE) && (!rsp_valid_ff || rsp_tready);
      cell_op      = OP_HOLD;
      count_in     = count_ff;
      step_in      = step_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      rpos_in      = rpos_ff;
      hit_in       = hit_ff;
      hit_pos_in   = hit_pos_ff;
      rd_char_in   = rd_char_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         STATE_IDLE: begin
            if (accept) begin
               cmd_in     = req_cmd;
               key_in     = req_char;
               rpos_in    = req_pos;
               hit_in     = 1'b0;
               hit_pos_in = '0;
               rd_char_in = '0;
               step_in    = '0;
               if (!needs_scan) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = imm_rsp;
               end
               unique case (req_cmd)
                  CMD_PUSH: begin
                     if (!is_full) begin
                        cell_op  = OP_DOWN;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_POP: begin
                     if (!is_empty) begin
                        cell_op  = OP_UP;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  default: ;
               endcase
            end
         end
         STATE_SCAN: begin
            // one ring rotation per cycle; DEPTH steps restore the order
            cell_op = OP_UP;
            if (scan_hit) begin
               hit_in     = 1'b1;
               hit_pos_in = step_pos[POS_W-1:0];
            end
            if (scan_rd) rd_char_in = top_data;
            if (step_ff == LAST_STEP) begin
               step_in          = '0;
               rsp_valid_in     = 1'b1;
               rsp_in.status    = ST_OK;
               rsp_in.char_out  = '0;
               rsp_in.position_out = '0;
               if (cmd_ff == CMD_SEARCH) begin
                  if (hit_in) rsp_in.position_out = hit_pos_in;
                  else        rsp_in.status       = ST_MISS;
               end else begin
                  rsp_in.char_out = rd_char_in;
               end
            end else begin
               step_in = step_ff + IDX_W'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      key_ff     <= key_in;
      rpos_ff    <= rpos_in;
      hit_ff     <= hit_in;
      hit_pos_ff <= hit_pos_in;
      rd_char_ff <= rd_char_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp        = rsp_ff;

endmodule

>>> src/csws_checker.sv
// ----------------------------------------------------------------------------
// csws_checker
// Port-level checks on the byte stack, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "char_stack_with_search_macros.svh"

module csws_checker
   import csws_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic [1:0]            req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]            rsp_tuser
);

   logic rsp_stall;
   logic push_take;
   logic rsp_is_error;
   logic push_rsp_ok;

   assign rsp_stall    = rsp_tvalid && !rsp_tready;
   assign push_take    = req_tvalid && req_tready && (req_tuser == CMD_PUSH);
   assign rsp_is_error = rsp_tvalid && (rsp_tuser != ST_OK);
   assign push_rsp_ok  = rsp_tvalid && (rsp_tdata == '0)
                         && (rsp_tuser == ST_OK || rsp_tuser == ST_FULL);

   `CSWS_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid, "result word dropped while stalled")
   `CSWS_ASSERT_NOW(a_no_take_when_blocked, rsp_stall, !req_tready, "word taken while blocked")
   `CSWS_ASSERT_NOW(a_error_zero, rsp_is_error, rsp_tdata == '0, "error result carries data")
   `CSWS_ASSERT_NEXT(a_push_quick, push_take, push_rsp_ok, "push result wrong or late")

endmodule

bind char_stack_with_search csws_checker u_csws_checker (.*);
